// ===== hdl/ppp_pkg.sv =====
// ppp_pkg: shared constants, beat types and helper functions for the
// polyline point projection core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppp_pkg;

    localparam int MAX_V  = 64;                 // vertex capacity
    localparam int AW     = $clog2(MAX_V);      // store address width
    localparam int CW     = $clog2(MAX_V + 1);  // vertex count width
    localparam int FRAC   = 16;                 // fraction bits of t and of the ratio
    localparam int ARC_W  = 40;
    localparam int QW     = 34;                 // root / quotient width
    localparam int SQ_STEPS = 34;               // root digits of a 68-bit radicand

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
    } t_in_beat;

    typedef struct packed {
        logic [ARC_W-1:0] arc_distance;
        logic [1:0]       status;
    } t_out_beat;

    typedef struct packed {
        logic [32:0] a;
        logic [32:0] b;
        logic        neg;
    } t_mul_req;

    typedef struct packed {
        logic        start;
        logic        sqrt;
        logic [67:0] num;
        logic [65:0] den;
        logic [5:0]  steps;
        logic        q0;
    } t_dsq_req;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] q;
    } t_dsq_rsp;

    typedef struct packed {
        logic               en;
        logic [AW-1:0]      addr;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [ARC_W-1:0]   cum;
    } t_st_wr;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [ARC_W-1:0]   cum;
    } t_st_rd;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ppp_mul.sv =====
// ppp_mul: shared 33x33 magnitude multiplier with sign, output registered.
// Depends on ppp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppp_mul
    import ppp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_mul_req           i_req,
    output logic signed [66:0]      o_prod
);

    logic [65:0]        w_mag;
    logic signed [66:0] r_prod;

    assign w_mag = 66'(i_req.a) * 66'(i_req.b);

    always_ff @(posedge i_clk) begin
        r_prod <= i_req.neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== hdl/ppp_dsq.sv =====
// ppp_dsq: restoring divider / square root, one digit per cycle.
// Depends on ppp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppp_dsq
    import ppp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_dsq_req  i_req,
    output t_dsq_rsp       o_rsp
);

    logic          r_busy;
    logic          r_done;
    logic [5:0]    r_cnt;
    logic          r_sqrt;
    logic [66:0]   r_rem;
    logic [67:0]   r_rad;
    logic [65:0]   r_den;
    logic [QW-1:0] r_q;

    logic [68:0] w_sh;
    logic [68:0] w_trial;
    logic        w_ge;

    always_comb begin
        w_sh    = r_sqrt ? {r_rem, r_rad[67:66]} : 69'({r_rem, 1'b0});
        w_trial = r_sqrt ? 69'({r_q, 2'b01}) : 69'(r_den);
        w_ge    = w_sh >= w_trial;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.sqrt;
            r_rem  <= i_req.sqrt ? '0 : i_req.num[66:0];
            r_rad  <= i_req.num;
            r_den  <= i_req.den;
            r_q    <= QW'(i_req.q0);
        end else if (r_busy) begin
            r_rem <= 67'(w_ge ? (w_sh - w_trial) : w_sh);
            r_rad <= {r_rad[65:0], 2'b00};
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

endmodule

`default_nettype wire

// ===== hdl/ppp_store.sv =====
// ppp_store: vertex x, y and cumulative length memories, one write and one
// registered read port. Depends on ppp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppp_store
    import ppp_pkg::*;
(
    input  wire logic          i_clk,
    input  wire t_st_wr        i_wr,
    input  wire logic [AW-1:0] i_raddr,
    output t_st_rd             o_rd
);

    logic signed [31:0] mem_x [MAX_V];
    logic signed [31:0] mem_y [MAX_V];
    logic [ARC_W-1:0]   mem_c [MAX_V];
    t_st_rd             r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_x[i_wr.addr] <= i_wr.x;
            mem_y[i_wr.addr] <= i_wr.y;
            mem_c[i_wr.addr] <= i_wr.cum;
        end
        r_rd.x   <= mem_x[i_raddr];
        r_rd.y   <= mem_y[i_raddr];
        r_rd.cum <= mem_c[i_raddr];
    end

    assign o_rd = r_rd;

endmodule

`default_nettype wire

// ===== hdl/polyline_point_projection_core.sv =====
// polyline_point_projection_core: top level, sequencer and datapath registers.
// Depends on ppp_pkg, ppp_mul, ppp_dsq, ppp_store.
//
// Holds a polyline of up to 64 vertices (signed Q15.16) and projects query
// points onto it. An append beat stores the vertex with its cumulative arc
// length (segment length by integer square root); a query beat walks every
// segment, clamps the projection parameter to 0..1, keeps the first nearest
// projection and returns its arc length in Q24.16, or the ratio to the total
// length when normalize_result is set. A clear beat empties the polyline.
// Only queries produce an output beat. One beat is worked at a time and
// o_in_stall stays high until the sequencer is back at idle;
// the output register lets the next beat enter while a result waits.
// Timing: all work runs through one shared multiplier (one product per cycle)
// and one restoring divide/root unit (one digit per cycle). An append works
// out 34 root digits; a query works out 16 quotient digits per interior
// segment, and a normalised query ends with a further divide. No clearing
// pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module polyline_point_projection_core
    import ppp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_data,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE, S_ARD, S_ADX, S_AM0, S_AM1, S_AM2, S_ASQ, S_AWR,
        S_QRD0, S_QLD0, S_QRD1, S_QLD1,
        S_QM0, S_QM1, S_QM2, S_QM3, S_QM4, S_QCLS, S_QDIV,
        S_QS0, S_QS1, S_QS2, S_QS3, S_QS4,
        S_QE, S_QD0, S_QD1, S_QD2, S_NDIV, S_OUT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_cnt;
    logic               r_norm;
    logic signed [31:0] r_px, r_py;
    logic [AW-1:0]      r_raddr, r_i;
    logic signed [31:0] r_x0, r_y0, r_x1, r_y1, r_qx, r_qy;
    logic [ARC_W-1:0]   r_c0, r_c1, r_a, r_arc;
    logic signed [32:0] r_vx, r_vy, r_ax, r_ay;   // r_ax/r_ay hold the error in the D steps
    logic signed [66:0] r_acc, r_dot;
    logic [64:0]        r_vv, r_best;
    logic [FRAC-1:0]    r_t;
    logic               r_first;
    logic [QW-1:0]      r_len;
    t_out_beat          r_res;
    logic               r_ovld;
    t_out_beat          r_odata;

    t_mul_req           w_mreq;
    logic signed [66:0] w_p;
    t_dsq_req           w_dreq;
    t_dsq_rsp           w_drsp;
    t_st_wr             w_wr;
    t_st_rd             w_rd;

    logic signed [66:0] w_sum;
    logic [ARC_W-1:0]   w_seg;
    logic [32:0]        w_shm;
    logic signed [33:0] w_qoff, w_qc;
    logic [65:0]        w_segsum;
    logic [41:0]        w_anew;
    logic               w_dot_pos, w_ge_vv, w_interior;
    logic [64:0]        w_d;
    logic               w_better, w_last, w_tot_hit;
    logic [ARC_W-1:0]   w_arc_n;
    logic [ARC_W:0]     w_cum_sum;
    logic               w_out_load;

    ppp_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mreq),
        .o_prod (w_p)
    );

    ppp_dsq u_dsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    ppp_store u_store (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (r_raddr),
        .o_rd    (w_rd)
    );

    // datapath helpers
    always_comb begin
        w_sum      = r_acc + w_p;
        w_seg      = r_c1 - r_c0;
        // scaled coordinate offset, truncated toward zero
        w_shm      = 33'(w_p[65:0] >> FRAC);
        w_qoff     = ((r_state == S_QS1) ? r_vx[32] : r_vy[32]) ?
                     -$signed({1'b0, w_shm}) : $signed({1'b0, w_shm});
        w_qc       = 34'((r_state == S_QS1) ? r_x0 : r_y0) + w_qoff;
        // seg * t from two partial products (low 32 bits, high 8 bits)
        w_segsum   = r_acc[65:0] + (w_p[65:0] << 32);
        w_anew     = 42'(r_c0) + 42'(w_segsum >> FRAC);
        w_dot_pos  = !r_dot[66] && (r_dot != '0);
        w_ge_vv    = r_dot[65:0] >= 66'(r_vv);
        w_interior = (r_vv != '0) && w_dot_pos && !w_ge_vv;
        w_d        = w_sum[64:0];
        w_better   = r_first || (w_d < r_best);
        w_arc_n    = w_better ? r_a : r_arc;
        w_last     = (CW'(r_i) + CW'(2)) >= r_cnt;
        w_tot_hit  = (w_arc_n == r_c1);
        w_cum_sum  = (ARC_W + 1)'(r_c0) + (ARC_W + 1)'(r_len);
        w_out_load = (r_state == S_OUT) && (!r_ovld || !i_out_stall);
    end

    // multiplier operand select: issued in one state, consumed in the next
    always_comb begin
        w_mreq = '0;
        case (r_state)
            S_AM0, S_QM0: begin
                w_mreq.a = mag33(r_vx);
                w_mreq.b = mag33(r_vx);
            end
            S_AM1, S_QM1: begin
                w_mreq.a = mag33(r_vy);
                w_mreq.b = mag33(r_vy);
            end
            S_QM2: begin
                w_mreq.a   = mag33(r_ax);
                w_mreq.b   = mag33(r_vx);
                w_mreq.neg = r_ax[32] ^ r_vx[32];
            end
            S_QM3: begin
                w_mreq.a   = mag33(r_ay);
                w_mreq.b   = mag33(r_vy);
                w_mreq.neg = r_ay[32] ^ r_vy[32];
            end
            S_QS0: begin
                w_mreq.a = mag33(r_vx);
                w_mreq.b = 33'(r_t);
            end
            S_QS1: begin
                w_mreq.a = mag33(r_vy);
                w_mreq.b = 33'(r_t);
            end
            S_QS2: begin
                w_mreq.a = 33'(w_seg[31:0]);
                w_mreq.b = 33'(r_t);
            end
            S_QS3: begin
                w_mreq.a = 33'(w_seg[ARC_W-1:32]);
                w_mreq.b = 33'(r_t);
            end
            S_QD0: begin
                w_mreq.a = mag33(r_ax);
                w_mreq.b = mag33(r_ax);
            end
            S_QD1: begin
                w_mreq.a = mag33(r_ay);
                w_mreq.b = mag33(r_ay);
            end
            default: begin
                w_mreq = '0;
            end
        endcase
    end

    // divide / root launch
    always_comb begin
        w_dreq = '0;
        case (r_state)
            S_AM2: begin
                w_dreq.start = 1'b1;
                w_dreq.sqrt  = 1'b1;
                w_dreq.num   = 68'(w_sum[65:0]);
                w_dreq.steps = 6'(SQ_STEPS);
            end
            S_QCLS: begin
                w_dreq.start = w_interior;
                w_dreq.num   = 68'(r_dot[65:0]);
                w_dreq.den   = 66'(r_vv);
                w_dreq.steps = 6'(FRAC);
            end
            S_QD2: begin
                // arc never exceeds the total, so the integer digit is arc == total
                w_dreq.start = w_last && r_norm && (r_c1 != '0);
                w_dreq.num   = w_tot_hit ? '0 : 68'(w_arc_n);
                w_dreq.den   = 66'(r_c1);
                w_dreq.steps = 6'(FRAC);
                w_dreq.q0    = w_tot_hit;
            end
            default: begin
                w_dreq = '0;
            end
        endcase
    end

    // vertex write at the end of an append
    always_comb begin
        w_wr.en   = (r_state == S_AWR);
        w_wr.addr = r_cnt[AW-1:0];
        w_wr.x    = r_px;
        w_wr.y    = r_py;
        w_wr.cum  = w_cum_sum[ARC_W] ? {ARC_W{1'b1}} : w_cum_sum[ARC_W-1:0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_norm  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_norm <= i_cfg_wdata;
            end
            // output register: load a new result, or free it once taken
            if (w_out_load) begin
                r_ovld  <= 1'b1;
                r_odata <= r_res;
            end else if (r_ovld && !i_out_stall) begin
                r_ovld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_px <= i_in_data.coord_x;
                        r_py <= i_in_data.coord_y;
                        case (i_in_data.kind)
                            KIND_APPEND: begin
                                if (r_cnt == '0) begin
                                    r_c0    <= '0;
                                    r_len   <= '0;
                                    r_state <= S_AWR;
                                end else if (r_cnt != CW'(MAX_V)) begin
                                    r_raddr <= AW'(r_cnt - CW'(1));
                                    r_state <= S_ARD;
                                end
                            end
                            KIND_QUERY: begin
                                if (r_cnt < CW'(2)) begin
                                    r_res.arc_distance <= '0;
                                    r_res.status       <= ST_FEW;
                                    r_state            <= S_OUT;
                                end else begin
                                    r_raddr <= '0;
                                    r_i     <= '0;
                                    r_first <= 1'b1;
                                    r_state <= S_QRD0;
                                end
                            end
                            KIND_CLEAR: begin
                                r_cnt <= '0;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end

                // append: read previous vertex, square, root, write
                S_ARD: r_state <= S_ADX;
                S_ADX: begin
                    r_vx    <= 33'(r_px) - 33'(w_rd.x);
                    r_vy    <= 33'(r_py) - 33'(w_rd.y);
                    r_c0    <= w_rd.cum;
                    r_state <= S_AM0;
                end
                S_AM0: r_state <= S_AM1;
                S_AM1: begin
                    r_acc   <= w_p;
                    r_state <= S_AM2;
                end
                S_AM2: r_state <= S_ASQ;
                S_ASQ: begin
                    if (w_drsp.done) begin
                        r_len   <= w_drsp.q;
                        r_state <= S_AWR;
                    end
                end
                S_AWR: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_state <= S_IDLE;
                end

                // query: segment walk
                S_QRD0: begin
                    r_raddr <= AW'(1);
                    r_state <= S_QLD0;
                end
                S_QLD0: begin
                    r_x0    <= w_rd.x;
                    r_y0    <= w_rd.y;
                    r_c0    <= w_rd.cum;
                    r_state <= S_QRD1;
                end
                S_QRD1: r_state <= S_QLD1;
                S_QLD1: begin
                    r_x1    <= w_rd.x;
                    r_y1    <= w_rd.y;
                    r_c1    <= w_rd.cum;
                    r_vx    <= 33'(w_rd.x) - 33'(r_x0);
                    r_vy    <= 33'(w_rd.y) - 33'(r_y0);
                    r_ax    <= 33'(r_px) - 33'(r_x0);
                    r_ay    <= 33'(r_py) - 33'(r_y0);
                    r_state <= S_QM0;
                end
                S_QM0: r_state <= S_QM1;
                S_QM1: begin
                    r_acc   <= w_p;
                    r_state <= S_QM2;
                end
                S_QM2: begin
                    r_vv    <= w_sum[64:0];
                    r_state <= S_QM3;
                end
                S_QM3: begin
                    r_acc   <= w_p;
                    r_state <= S_QM4;
                end
                S_QM4: begin
                    r_dot   <= w_sum;
                    r_state <= S_QCLS;
                end
                S_QCLS: begin
                    if (w_interior) begin
                        r_state <= S_QDIV;
                    end else if (r_vv == '0 || !w_dot_pos) begin
                        // degenerate or behind the start: start vertex
                        r_qx    <= r_x0;
                        r_qy    <= r_y0;
                        r_a     <= r_c0;
                        r_state <= S_QE;
                    end else begin
                        r_qx    <= r_x1;
                        r_qy    <= r_y1;
                        r_a     <= r_c1;
                        r_state <= S_QE;
                    end
                end
                S_QDIV: begin
                    if (w_drsp.done) begin
                        r_t     <= w_drsp.q[FRAC-1:0];
                        r_state <= S_QS0;
                    end
                end
                S_QS0: r_state <= S_QS1;
                S_QS1: begin
                    r_qx    <= w_qc[31:0];
                    r_state <= S_QS2;
                end
                S_QS2: begin
                    r_qy    <= w_qc[31:0];
                    r_state <= S_QS3;
                end
                S_QS3: begin
                    r_acc   <= w_p;
                    r_state <= S_QS4;
                end
                S_QS4: begin
                    r_a     <= (w_anew > 42'(r_c1)) ? r_c1 : w_anew[ARC_W-1:0];
                    r_state <= S_QE;
                end
                S_QE: begin
                    r_ax    <= 33'(r_px) - 33'(r_qx);
                    r_ay    <= 33'(r_py) - 33'(r_qy);
                    r_state <= S_QD0;
                end
                S_QD0: r_state <= S_QD1;
                S_QD1: begin
                    r_acc   <= w_p;
                    r_state <= S_QD2;
                end
                S_QD2: begin
                    r_first <= 1'b0;
                    if (w_better) begin
                        r_best <= w_d;
                        r_arc  <= r_a;
                    end
                    if (!w_last) begin
                        r_i     <= r_i + AW'(1);
                        r_raddr <= AW'(CW'(r_i) + CW'(2));
                        r_x0    <= r_x1;
                        r_y0    <= r_y1;
                        r_c0    <= r_c1;
                        r_state <= S_QRD1;
                    end else if (!r_norm) begin
                        r_res.arc_distance <= w_arc_n;
                        r_res.status       <= ST_OK;
                        r_state            <= S_OUT;
                    end else if (r_c1 == '0) begin
                        r_res.arc_distance <= '0;
                        r_res.status       <= ST_ZERO;
                        r_state            <= S_OUT;
                    end else begin
                        r_state <= S_NDIV;
                    end
                end
                S_NDIV: begin
                    if (w_drsp.done) begin
                        r_res.arc_distance <= ARC_W'(w_drsp.q[FRAC:0]);
                        r_res.status       <= ST_OK;
                        r_state            <= S_OUT;
                    end
                end

                // hand the result to the output register once it is free
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_V))
        else $error("vertex count beyond capacity");

    a_wr_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> (r_cnt < CW'(MAX_V)))
        else $error("vertex write with store full");

    a_dsq_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drsp.done |-> (r_state == S_ASQ || r_state == S_QDIV || r_state == S_NDIV))
        else $error("divide/root finished outside a wait state");

    a_few_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_res.status == ST_FEW) |-> (r_cnt < CW'(2)))
        else $error("short-polyline status with enough vertices");

endmodule

`default_nettype wire

// ===== dv/ppp_projection_checker.sv =====
// ppp_projection_checker: watches the in/out channels of the polyline point
// projection core, predicts each query result and compares. Depends on ppp_pkg.
`timescale 1ns / 1ps

module ppp_projection_checker
    import ppp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results_seen
);

    localparam logic [39:0] ARC_SAT = 40'hFF_FFFF_FFFF;

    logic signed [31:0] poly_x   [MAX_V];
    logic signed [31:0] poly_y   [MAX_V];
    logic [39:0]        poly_cum [MAX_V];
    int                 poly_count;
    logic               norm_mode;
    t_out_beat          expected_results [$];

    function automatic logic [127:0] sq_sum(input logic signed [63:0] ex,
                                            input logic signed [63:0] ey);
        logic signed [127:0] sx, sy;
        sx = ex;
        sy = ey;
        return 128'(sx * sx) + 128'(sy * sy);
    endfunction

    function automatic logic [63:0] floor_root(input logic [127:0] s);
        logic [63:0] root, lo, hi, mid;
        lo = 0;
        hi = 64'h3_FFFF_FFFF;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (128'(mid) * 128'(mid) <= s) lo = mid;
            else hi = mid - 1;
        end
        root = lo;
        return root;
    endfunction

    // trunc toward zero of v*t / 2^FRAC
    function automatic logic signed [63:0] scale_t(input logic signed [63:0] v,
                                                   input logic [63:0] t);
        logic [63:0] m;
        m = ((v < 0 ? -v : v) * t) >> FRAC;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic t_out_beat project_point(input logic signed [63:0] px,
                                                input logic signed [63:0] py);
        t_out_beat r;
        logic signed [63:0] x0, y0, vx, vy, qx, qy;
        logic signed [127:0] dot;
        logic [127:0] vv, d, best_d;
        logic [63:0] t, a, arc, seg, total, q, rem;
        r.status = ST_OK;
        r.arc_distance = '0;
        arc = 0;
        best_d = 0;
        if (poly_count < 2) begin
            r.status = ST_FEW;
            return r;
        end
        for (int i = 0; i + 1 < poly_count; i++) begin
            x0 = poly_x[i];
            y0 = poly_y[i];
            vx = poly_x[i+1] - x0;
            vy = poly_y[i+1] - y0;
            vv = sq_sum(vx, vy);
            dot = 128'(128'(signed'(px - x0)) * 128'(signed'(vx)))
                + 128'(128'(signed'(py - y0)) * 128'(signed'(vy)));
            if (vv == 0 || dot <= 0) begin
                qx = x0; qy = y0; a = poly_cum[i];
            end else if ($unsigned(dot) >= vv) begin
                qx = x0 + vx; qy = y0 + vy; a = poly_cum[i+1];
            end else begin
                t = 64'((($unsigned(dot)) << FRAC) / vv);
                qx = x0 + scale_t(vx, t);
                qy = y0 + scale_t(vy, t);
                seg = poly_cum[i+1] - poly_cum[i];
                a = poly_cum[i] + ((seg * t) >> FRAC);
                if (a > poly_cum[i+1]) a = poly_cum[i+1];
            end
            d = sq_sum(px - qx, py - qy);
            if (i == 0 || d < best_d) begin
                best_d = d;
                arc = a;
            end
        end
        if (norm_mode) begin
            total = poly_cum[poly_count-1];
            if (total == 0) begin
                r.status = ST_ZERO;
                return r;
            end
            q = 0;
            rem = arc;
            if (rem >= total) begin q = 1; rem -= total; end
            if (rem >= total) rem = total - 1;
            for (int b = 0; b < FRAC; b++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= total) begin rem -= total; q |= 1; end
            end
            arc = q;
        end
        r.arc_distance = arc > ARC_SAT ? ARC_SAT : arc[39:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        logic [63:0] c;
        if (!i_rst_n) begin
            poly_count <= 0;
            norm_mode <= 1'b0;
            expected_results.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_cfg_we) norm_mode <= i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                case (i_in_data.kind)
                    KIND_CLEAR: poly_count <= 0;
                    KIND_APPEND: begin
                        if (poly_count < MAX_V) begin
                            poly_x[poly_count] <= i_in_data.coord_x;
                            poly_y[poly_count] <= i_in_data.coord_y;
                            if (poly_count == 0) begin
                                poly_cum[0] <= '0;
                            end else begin
                                c = 64'(poly_cum[poly_count-1]) + floor_root(sq_sum(
                                    64'(i_in_data.coord_x) - 64'(poly_x[poly_count-1]),
                                    64'(i_in_data.coord_y) - 64'(poly_y[poly_count-1])));
                                poly_cum[poly_count] <= c > ARC_SAT ? ARC_SAT : c[39:0];
                            end
                            poly_count <= poly_count + 1;
                        end
                    end
                    KIND_QUERY: expected_results.insert(expected_results.size(),
                        project_point(i_in_data.coord_x, i_in_data.coord_y));
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    t_out_beat e;
                    e = expected_results.pop_front();
                    if (e.arc_distance !== i_out_data.arc_distance) begin
                        $error("arc_distance: expected %0h actual %0h",
                               e.arc_distance, i_out_data.arc_distance);
                        o_fail_count <= o_fail_count + 1;
                    end else if (e.status !== i_out_data.status) begin
                        $error("status: expected %0d actual %0d",
                               e.status, i_out_data.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    assign o_pending = expected_results.size();

endmodule

// ===== dv/tb_polyline_point_projection_core.sv =====
// tb_polyline_point_projection_core: stimulus and verdict for the polyline
// point projection core. Depends on ppp_pkg and ppp_projection_checker.
`timescale 1ns / 1ps

module tb_polyline_point_projection_core;
    import ppp_pkg::*;

    localparam int CYCLE_LIMIT = 10_000_000;

    logic      clk, rst_n;
    logic      in_valid, in_stall, out_valid, out_stall;
    t_in_beat  in_data;
    t_out_beat out_data;
    logic      cfg_we, cfg_wdata;
    int        fail_count, pending, results_seen;
    int        cycle_count;
    bit        quiet_tail;   // no idling on either side near the end
    int        queries_sent, appends_sent;

    polyline_point_projection_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata)
    );

    ppp_projection_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    always begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver stall: random bursts, none during the quiet tail.
    initial begin
        int burst;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 3);
                repeat (burst) begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= 1'b0;
        end
    end

    // Send one beat: optional idle burst first, then hold until accepted.
    // Valid is left high at return; the next beat, an idle burst or the
    // caller drops it at the same falling edge.
    task automatic send_beat(input logic [1:0] kind, input logic [31:0] x,
                             input logic [31:0] y);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data.kind <= kind;
        in_data.coord_x <= x;
        in_data.coord_y <= y;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        if (kind == KIND_QUERY) queries_sent++;
        if (kind == KIND_APPEND) appends_sent++;
    endtask

    // Wait for all results, then let an in-flight append/clear drain before
    // touching the register.
    task automatic write_mode(input logic mode);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random coordinate: mostly modest values so segments are sensible,
    // sometimes full range to hit the extremes.
    function automatic logic [31:0] rand_coord(input int span);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    initial begin
        int nverts, span;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        quiet_tail = 1'b0;
        cycle_count = 0;
        queries_sent = 0;
        appends_sent = 0;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: query with no vertices and with one vertex
        send_beat(KIND_QUERY, 0, 0);
        send_beat(KIND_APPEND, 32'h0001_0000, 32'h0001_0000);
        send_beat(KIND_QUERY, 0, 0);
        // zero-length segment, then normalised query on zero total
        send_beat(KIND_APPEND, 32'h0001_0000, 32'h0001_0000);
        send_beat(KIND_QUERY, 32'h0005_0000, 32'hFFFF_0000);
        write_mode(1'b1);
        send_beat(KIND_QUERY, 32'h0005_0000, 32'h0002_0000);
        // extremes: opposite corners of the coordinate space
        send_beat(KIND_CLEAR, 0, 0);
        send_beat(KIND_APPEND, 32'h8000_0000, 32'h8000_0000);
        send_beat(KIND_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_beat(KIND_APPEND, 32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(KIND_QUERY, 32'h7FFF_FFFF, 32'h8000_0000);
        send_beat(KIND_QUERY, 0, 0);
        write_mode(1'b0);
        send_beat(KIND_QUERY, 32'hFFFF_FFFF, 32'h0000_0001);
        send_beat(KIND_QUERY, 32'h8000_0000, 32'h8000_0000);
        // unknown kind is ignored
        send_beat(2'd3, 32'h1234_5678, 32'h9ABC_DEF0);
        // fill past capacity, then query
        send_beat(KIND_CLEAR, 0, 0);
        for (int i = 0; i < MAX_V + 2; i++)
            send_beat(KIND_APPEND, 32'(i) << 17, 32'((i % 3) << 16));
        send_beat(KIND_QUERY, 32'h0040_0000, 32'h0000_8000);

        // Random: well-formed polylines with queries, with some noise
        for (int rounds = 0; queries_sent + appends_sent < 770; rounds++) begin
            if (rounds % 8 == 0) write_mode(rounds % 16 == 0 ? 1'b0 : 1'b1);
            if (queries_sent + appends_sent > 650) quiet_tail = 1'b1;
            send_beat(KIND_CLEAR, 0, 0);
            nverts = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 66)
                                                   : $urandom_range(2, 8);
            span = $urandom_range(0, 1) ? 32'h0010_0000 : 32'h4000_0000;
            for (int v = 0; v < nverts; v++)
                send_beat(KIND_APPEND, rand_coord(span), rand_coord(span));
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(2'd3, $urandom(), $urandom());
                send_beat(KIND_QUERY, rand_coord(span), rand_coord(span));
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        $display("covered %0d appends and %0d queries, %0d results checked",
                 appends_sent, queries_sent, results_seen);
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
